// File: design/bsl_pkg.sv
// Shared types, widths, codes and the line style function of the styled line rasterizer.
package bsl_pkg;

	localparam int COORD_BITS     = 12;
	localparam int DELTA_BITS     = COORD_BITS + 1;
	localparam int INC_S_BITS     = COORD_BITS + 2;
	localparam int ERR_BITS       = COORD_BITS + 4;
	localparam int COLOR_BITS     = 8;
	localparam int STYLE_BITS     = 2;
	localparam int PAT_PERIOD     = 9;
	localparam int POS_BITS       = $clog2(PAT_PERIOD);
	localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS + STYLE_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam logic [POS_BITS-1:0] PAT_LAST  = POS_BITS'(PAT_PERIOD - 1);
	localparam logic [POS_BITS-1:0] DOT_LEN   = POS_BITS'(3);
	localparam logic [POS_BITS-1:0] DASH_LEN  = POS_BITS'(6);
	localparam logic [POS_BITS-1:0] DD_DASH   = POS_BITS'(2);
	localparam logic [POS_BITS-1:0] DD_DOT    = POS_BITS'(7);

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	localparam logic [STYLE_BITS-1:0] STYLE_SOLID    = 2'd0;
	localparam logic [STYLE_BITS-1:0] STYLE_DOTTED   = 2'd1;
	localparam logic [STYLE_BITS-1:0] STYLE_DASHED   = 2'd2;
	localparam logic [STYLE_BITS-1:0] STYLE_DASH_DOT = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t                         cur_x;
		coord_t                         cur_y;
		logic signed [ERR_BITS-1:0]     err_term;
		logic        [INC_S_BITS-1:0]   inc_straight;
		logic signed [ERR_BITS-1:0]     inc_diagonal;
		coord_t                         major_end;
		logic                           x_is_major;
		logic                           minor_up;
		logic        [POS_BITS-1:0]     pattern_pos;
		logic        [STYLE_BITS-1:0]   cur_style;
		logic        [COLOR_BITS-1:0]   cur_color;
		logic                           busy;
	} line_state_t;

	typedef struct packed {
		coord_t                   x;
		coord_t                   y;
		logic [COLOR_BITS-1:0]    color;
		logic                     plot;
		logic                     done;
		logic                     active;
	} pixel_t;

	typedef struct packed {
		coord_t                   x_start;
		coord_t                   y_start;
		coord_t                   x_end;
		coord_t                   y_end;
		logic [COLOR_BITS-1:0]    pen_color;
		logic [STYLE_BITS-1:0]    line_style;
	} start_req_t;

	function automatic logic style_plot(input logic [STYLE_BITS-1:0] style,
		input logic [POS_BITS-1:0] pos);
		logic hit;
		case (style)
			STYLE_SOLID:    hit = 1'b1;
			STYLE_DOTTED:   hit = pos < DOT_LEN;
			STYLE_DASHED:   hit = pos < DASH_LEN;
			STYLE_DASH_DOT: hit = (pos < DD_DASH) || (pos == DD_DOT);
			default:        hit = 1'b1;
		endcase
		return hit;
	endfunction

endpackage

// File: design/styled_bresenham_line.sv
// Top level of the styled line rasterizer: request register, line state and result register.
// A request is held in the request register, and its result is then registered in the result register.
// Throughput: one request per cycle while the output is not stalled, set by the loop through the
// error term adder and the line state register.
// Reset clears both pipeline valid flags and the line state; the block starts with no line.
module styled_bresenham_line (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36], pen_color[55:48],
	// line_style[57:56], zero padding above.
	input  logic [bsl_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
	// mode[0].
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pixel_x[11:0], pixel_y[23:12], pixel_color[31:24].
	output logic [bsl_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
	// plot[0], active[1].
	output logic [1:0]                          m_axis_tuser,
	output logic                                m_axis_tlast
);
	import bsl_pkg::*;

	logic                     valid_s1;
	logic                     mode_s1;
	logic [IN_FIELD_BITS-1:0] data_s1;
	logic                     valid_s2;
	pixel_t                   pix_s2;
	line_state_t              state_q;

	logic                     advance;
	start_req_t               req;
	line_state_t              setup_state;
	pixel_t                   setup_pix;
	line_state_t              step_state;
	pixel_t                   step_pix;
	line_state_t              nxt_state;
	pixel_t                   nxt_pix;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		req.x_start    = data_s1[COORD_BITS-1:0];
		req.y_start    = data_s1[2*COORD_BITS-1:COORD_BITS];
		req.x_end      = data_s1[3*COORD_BITS-1:2*COORD_BITS];
		req.y_end      = data_s1[4*COORD_BITS-1:3*COORD_BITS];
		req.pen_color  = data_s1[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
		req.line_style = data_s1[IN_FIELD_BITS-1:4*COORD_BITS+COLOR_BITS];
	end

	bsl_setup u_setup (
		.req       (req),
		.nxt_state (setup_state),
		.nxt_pix   (setup_pix)
	);

	bsl_stepper u_stepper (
		.cur_state (state_q),
		.nxt_state (step_state),
		.nxt_pix   (step_pix)
	);

	always_comb begin
		if (mode_s1 == MODE_START) begin
			nxt_state = setup_state;
			nxt_pix   = setup_pix;
		end else begin
			nxt_state = step_state;
			nxt_pix   = step_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata[IN_FIELD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			state_q  <= nxt_state;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s2 <= nxt_pix;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_DATA_BITS'({pix_s2.color, pix_s2.y, pix_s2.x});
	assign m_axis_tuser  = {pix_s2.active, pix_s2.plot};
	assign m_axis_tlast  = pix_s2.done;

	// An idle step request yields an all-zero result.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !pix_s2.active) |->
			(m_axis_tdata == '0 && !m_axis_tlast && !m_axis_tuser[0]))
		else $error("idle step result carries nonzero fields");

	// A start request always gives an active, plotted first pixel.
	a_start_plots: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1 == MODE_START) |=>
			(m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[0]))
		else $error("start request did not give a plotted pixel");

	// A waiting last pixel means the line state is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && pix_s2.active && pix_s2.done) |-> !state_q.busy)
		else $error("line still busy after its last pixel");

	// The style pattern position stays within its period.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pattern_pos <= PAT_LAST)
		else $error("pattern position out of range");

endmodule

// File: design/bsl_setup.sv
// Line setup logic: deltas, major axis, error term and the first pixel of a new line.
module bsl_setup (
	input  bsl_pkg::start_req_t  req,
	output bsl_pkg::line_state_t nxt_state,
	output bsl_pkg::pixel_t      nxt_pix
);
	import bsl_pkg::*;

	logic signed [DELTA_BITS-1:0] dx;
	logic signed [DELTA_BITS-1:0] dy;
	logic        [DELTA_BITS-1:0] adx_full;
	logic        [DELTA_BITS-1:0] ady_full;
	logic        [COORD_BITS-1:0] adx;
	logic        [COORD_BITS-1:0] ady;
	logic        [COORD_BITS-1:0] maj;
	logic        [COORD_BITS-1:0] mnr;
	logic                         x_major;
	logic                         first_is_start;
	coord_t                       first_x;
	coord_t                       first_y;
	coord_t                       end_major;
	coord_t                       first_major;
	logic                         done;

	always_comb begin
		dx = {req.x_end[COORD_BITS-1], req.x_end} - {req.x_start[COORD_BITS-1], req.x_start};
		dy = {req.y_end[COORD_BITS-1], req.y_end} - {req.y_start[COORD_BITS-1], req.y_start};
		adx_full = dx[DELTA_BITS-1] ? -dx : dx;
		ady_full = dy[DELTA_BITS-1] ? -dy : dy;
		adx = adx_full[COORD_BITS-1:0];
		ady = ady_full[COORD_BITS-1:0];
		x_major = ady <= adx;
		maj = x_major ? adx : ady;
		mnr = x_major ? ady : adx;
		first_is_start = x_major ? !dx[DELTA_BITS-1] : !dy[DELTA_BITS-1];
		if (first_is_start) begin
			first_x = req.x_start;
			first_y = req.y_start;
			end_major = x_major ? req.x_end : req.y_end;
		end else begin
			first_x = req.x_end;
			first_y = req.y_end;
			end_major = x_major ? req.x_start : req.y_start;
		end
		first_major = x_major ? first_x : first_y;
		done = first_major >= end_major;

		nxt_state.cur_x        = first_x;
		nxt_state.cur_y        = first_y;
		nxt_state.err_term     = ERR_BITS'({mnr, 1'b0}) - ERR_BITS'(maj);
		nxt_state.inc_straight = INC_S_BITS'({mnr, 1'b0});
		nxt_state.inc_diagonal = ERR_BITS'({mnr, 1'b0}) - ERR_BITS'({maj, 1'b0});
		nxt_state.major_end    = end_major;
		nxt_state.x_is_major   = x_major;
		nxt_state.minor_up     = (dx != '0) && (dy != '0) &&
			(dx[DELTA_BITS-1] == dy[DELTA_BITS-1]);
		nxt_state.pattern_pos  = '0;
		nxt_state.cur_style    = req.line_style;
		nxt_state.cur_color    = req.pen_color;
		nxt_state.busy         = !done;

		nxt_pix.x      = first_x;
		nxt_pix.y      = first_y;
		nxt_pix.color  = req.pen_color;
		nxt_pix.plot   = 1'b1;
		nxt_pix.done   = done;
		nxt_pix.active = 1'b1;
	end

endmodule

// File: design/bsl_stepper.sv
// Step logic: advances a busy line by one pixel along its major axis; an idle line yields an all-zero pixel.
module bsl_stepper (
	input  bsl_pkg::line_state_t cur_state,
	output bsl_pkg::line_state_t nxt_state,
	output bsl_pkg::pixel_t      nxt_pix
);
	import bsl_pkg::*;

	coord_t minor_step;
	coord_t new_x;
	coord_t new_y;
	coord_t new_major;
	logic   go_straight;
	logic   done;

	always_comb begin
		minor_step = cur_state.minor_up ? coord_t'(1) : '1;
		nxt_state = cur_state;
		if (cur_state.x_is_major) begin
			go_straight = cur_state.err_term[ERR_BITS-1];
		end else begin
			go_straight = cur_state.err_term[ERR_BITS-1] || (cur_state.err_term == '0);
		end
		new_x = cur_state.cur_x;
		new_y = cur_state.cur_y;
		if (cur_state.x_is_major) begin
			new_x = cur_state.cur_x + coord_t'(1);
			if (!go_straight) begin
				new_y = cur_state.cur_y + minor_step;
			end
		end else begin
			new_y = cur_state.cur_y + coord_t'(1);
			if (!go_straight) begin
				new_x = cur_state.cur_x + minor_step;
			end
		end
		new_major = cur_state.x_is_major ? new_x : new_y;
		done = new_major >= cur_state.major_end;

		nxt_pix = '0;
		if (cur_state.busy) begin
			nxt_state.cur_x = new_x;
			nxt_state.cur_y = new_y;
			nxt_state.err_term = go_straight ?
				cur_state.err_term + ERR_BITS'(cur_state.inc_straight) :
				cur_state.err_term + cur_state.inc_diagonal;
			nxt_state.pattern_pos = (cur_state.pattern_pos >= PAT_LAST) ? '0 :
				cur_state.pattern_pos + POS_BITS'(1);
			nxt_state.busy = !done;

			nxt_pix.x      = new_x;
			nxt_pix.y      = new_y;
			nxt_pix.color  = cur_state.cur_color;
			nxt_pix.plot   = style_plot(cur_state.cur_style, cur_state.pattern_pos);
			nxt_pix.done   = done;
			nxt_pix.active = 1'b1;
		end
	end

endmodule

// File: tb/styled_bresenham_line_tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the styled line rasterizer, with its own line predictor.
module styled_bresenham_line_tb;
	import bsl_pkg::*;

	typedef struct {
		logic       mode;
		start_req_t body;
	} raster_cmd_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     s_axis_tvalid  = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata   = '0;
	logic                     s_axis_tuser   = MODE_START;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic [1:0]               m_axis_tuser;
	logic                     m_axis_tlast;

	raster_cmd_t cmd_q[$];
	pixel_t      pixel_q[$];

	int   accepted_cnt = 0;
	int   mismatches   = 0;
	int   sender_gap   = 0;
	int   receiver_gap = 0;
	logic long_hold    = 1'b0;
	logic drain_hold   = 1'b0;

	int                    pen_x      = 0;
	int                    pen_y      = 0;
	int                    err_acc    = 0;
	int                    inc_flat   = 0;
	int                    inc_diag   = 0;
	int                    major_stop = 0;
	int                    pat_idx    = 0;
	bit                    along_x    = 1'b0;
	bit                    minor_inc  = 1'b0;
	bit                    drawing    = 1'b0;
	logic [STYLE_BITS-1:0] pen_style  = STYLE_SOLID;
	logic [COLOR_BITS-1:0] pen_col    = '0;

	styled_bresenham_line u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic pattern_hit(logic [STYLE_BITS-1:0] style, int pos);
		case (style)
			STYLE_SOLID:  return 1'b1;
			STYLE_DOTTED: return pos < DOT_LEN;
			STYLE_DASHED: return pos < DASH_LEN;
			default:      return (pos < DD_DASH) || (pos == DD_DOT);
		endcase
	endfunction

	function automatic pixel_t rasterize(raster_cmd_t r);
		int     xs, ys, xe, ye, dx, dy, adx, ady, maj, mnr, lead;
		pixel_t px;
		px = '0;
		if (r.mode == MODE_START) begin
			xs = r.body.x_start;
			ys = r.body.y_start;
			xe = r.body.x_end;
			ye = r.body.y_end;
			dx = xe - xs;
			dy = ye - ys;
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			pen_col = r.body.pen_color;
			pen_style = r.body.line_style;
			along_x = ady <= adx;
			minor_inc = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
			maj = along_x ? adx : ady;
			mnr = along_x ? ady : adx;
			err_acc = 2 * mnr - maj;
			inc_flat = 2 * mnr;
			inc_diag = 2 * (mnr - maj);
			if (along_x ? (dx >= 0) : (dy >= 0)) begin
				pen_x = xs;
				pen_y = ys;
				major_stop = along_x ? xe : ye;
			end else begin
				pen_x = xe;
				pen_y = ye;
				major_stop = along_x ? xs : ys;
			end
			pat_idx = 0;
			px.plot = 1'b1;
		end else begin
			if (!drawing)
				return px;
			if (along_x) begin
				pen_x++;
				if (err_acc < 0) begin
					err_acc += inc_flat;
				end else begin
					pen_y += minor_inc ? 1 : -1;
					err_acc += inc_diag;
				end
			end else begin
				pen_y++;
				if (err_acc <= 0) begin
					err_acc += inc_flat;
				end else begin
					pen_x += minor_inc ? 1 : -1;
					err_acc += inc_diag;
				end
			end
			px.plot = pattern_hit(pen_style, pat_idx);
			pat_idx = (pat_idx >= PAT_LAST) ? 0 : pat_idx + 1;
		end
		lead = along_x ? pen_x : pen_y;
		px.done = lead >= major_stop;
		drawing = !px.done;
		px.x = coord_t'(pen_x);
		px.y = coord_t'(pen_y);
		px.color = pen_col;
		px.active = 1'b1;
		return px;
	endfunction

	function automatic void push_start(int xs, int ys, int xe, int ye, int color,
		logic [STYLE_BITS-1:0] style);
		raster_cmd_t c;
		c.mode = MODE_START;
		c.body.x_start = coord_t'(xs);
		c.body.y_start = coord_t'(ys);
		c.body.x_end = coord_t'(xe);
		c.body.y_end = coord_t'(ye);
		c.body.pen_color = COLOR_BITS'(color);
		c.body.line_style = style;
		cmd_q.push_back(c);
	endfunction

	function automatic void push_step();
		raster_cmd_t c;
		c.mode = MODE_STEP;
		c.body = start_req_t'(IN_FIELD_BITS'({$urandom, $urandom}));
		cmd_q.push_back(c);
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 19))
			0:       return -2048;
			1:       return 2047;
			default: return int'($urandom_range(0, 4095)) - 2048;
		endcase
	endfunction

	function automatic int far_end(int base, int span);
		int d, t;
		d = $urandom_range(0, span);
		if ($urandom_range(0, 1))
			d = -d;
		t = base + d;
		if (t > 2047 || t < -2048)
			t = base - d;
		return t;
	endfunction

	function automatic bit idling_on();
		return cmd_q.size() > 200 && ((accepted_cnt / 128) % 4) != 3;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pixel_q.push_back(rasterize(cmd_q.pop_front()));
				accepted_cnt++;
				if (accepted_cnt == 900)
					drain_hold = 1'b1;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (drain_hold && pixel_q.size() != 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					drain_hold = 1'b0;
					if (sender_gap > 0) begin
						sender_gap--;
						s_axis_tvalid <= 1'b0;
					end else if (cmd_q.size() == 0) begin
						s_axis_tvalid <= 1'b0;
					end else if (idling_on() && !long_hold && $urandom_range(0, 7) == 0) begin
						sender_gap = $urandom_range(0, 3);
						s_axis_tvalid <= 1'b0;
					end else begin
						s_axis_tvalid <= 1'b1;
						s_axis_tuser <= cmd_q[0].mode;
						s_axis_tdata <= IN_DATA_BITS'({cmd_q[0].body.line_style,
							cmd_q[0].body.pen_color, cmd_q[0].body.y_end,
							cmd_q[0].body.x_end, cmd_q[0].body.y_start,
							cmd_q[0].body.x_start});
					end
				end
			end
		end
	end

	always @(posedge clk) begin : pixel_monitor
		pixel_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[COORD_BITS-1:0];
				got.y = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
				got.color = m_axis_tdata[2*COORD_BITS +: COLOR_BITS];
				got.plot = m_axis_tuser[0];
				got.active = m_axis_tuser[1];
				got.done = m_axis_tlast;
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected pixel x=%0d y=%0d color=%0d", $time,
							got.x, got.y, got.color);
				end else begin
					want = pixel_q.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
						got.plot !== want.plot || got.done !== want.done ||
						got.active !== want.active) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: pixel mismatch: expected x=%0d y=%0d color=%0d ",
								"plot=%b done=%b active=%b, got x=%0d y=%0d color=%0d ",
								"plot=%b done=%b active=%b"}, $time, want.x, want.y,
								want.color, want.plot, want.done, want.active, got.x,
								got.y, got.color, got.plot, got.done, got.active);
					end
				end
			end
			if (long_hold) begin
				m_axis_tready <= 1'b0;
			end else if (receiver_gap > 0) begin
				receiver_gap--;
				m_axis_tready <= 1'b0;
			end else if (idling_on() && $urandom_range(0, 7) == 0) begin
				receiver_gap = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		wait (accepted_cnt >= 300);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (48) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int xs, ys, xe, ye, span, len, steps, line_items, ax, ay;
		line_items = 0;

		push_step();
		push_start(-2048, -2048, 2047, 2047, 255, STYLE_DASH_DOT);
		repeat (3) push_step();
		push_start(2047, -2048, -2048, 2047, 0, STYLE_DOTTED);
		repeat (2) push_step();
		push_start(5, -7, 5, -7, 170, STYLE_SOLID);
		push_step();
		push_start(3, 10, 1, 0, 85, STYLE_DASHED);
		repeat (11) push_step();

		while (line_items < 1700) begin
			if ($urandom_range(0, 99) < 6) begin
				push_step();
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:2]:   span = 300;
					[3:9]:   span = 1;
					default: span = 24;
				endcase
				xs = pick_coord();
				ys = pick_coord();
				xe = far_end(xs, span);
				ye = far_end(ys, span);
				ax = (xe > xs) ? xe - xs : xs - xe;
				ay = (ye > ys) ? ye - ys : ys - ye;
				len = (ax > ay) ? ax : ay;
				push_start(xs, ys, xe, ye, $urandom_range(0, 255),
					STYLE_BITS'($urandom_range(0, 3)));
				if (len > 0 && $urandom_range(0, 9) == 0)
					steps = $urandom_range(0, len - 1);
				else
					steps = len + $urandom_range(0, 2);
				repeat (steps) push_step();
				line_items += 1 + ((steps < len) ? steps : len);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_q.size() != 0 || pixel_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
